FILE: src/ptsgm_pkg.sv
// Shared widths and constants for the per-TID sequence gap monitor.
`timescale 1ns / 1ps

package ptsgm_pkg;

    localparam int TID_IN_W     = 4;
    localparam int SEQ_W        = 12;
    localparam int WIN_W        = 16;
    localparam int CNT_W        = 16;
    localparam int MISSED_W     = 27;
    localparam int TID_SPACE    = 1 << TID_IN_W;
    localparam int NUM_TIDS_DEF = 16;

    localparam logic [SEQ_W-1:0] SEQ_ONE      = SEQ_W'(1);
    localparam logic [SEQ_W-1:0] SEQ_TWO      = SEQ_W'(2);
    localparam logic [SEQ_W-1:0] HALF_SPACE   = SEQ_W'(2048);
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(2000);

endpackage

FILE: src/per_tid_seq_gap_monitor.sv
// Top level of the per-TID sequence gap monitor: classification, window counters and report.
//
//   channel  | ports                        | direction | carries
//   ---------+------------------------------+-----------+-------------------------------
//   s_       | s_valid / s_ready + fields   | in        | one decoded receive descriptor
//   m_       | m_valid / m_ready + fields   | out       | one window statistics report
//   cfg_     | cfg_we / cfg_wdata           | in        | window length in counted frames
//
// A request is taken into an input register and classified from that register against the
// per-TID table and the counters, so one request is accepted every cycle while the output
// register is empty or being drained. The report waits in an output register.
// The input register moves on whenever the output register is empty or being drained.
// Reset is synchronous and active low; it clears the counters, seen flags and valid bits.
`timescale 1ns / 1ps

module per_tid_seq_gap_monitor
    import ptsgm_pkg::*;
#(
    parameter int NUM_TIDS = NUM_TIDS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_we,
    input  logic [WIN_W-1:0]    cfg_wdata,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_crc_error,
    input  logic                s_icv_error,
    input  logic                s_is_qos,
    input  logic [TID_IN_W-1:0] s_traffic_id,
    input  logic [SEQ_W-1:0]    s_frame_seq,
    input  logic                s_retry_flag,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [CNT_W-1:0]    m_rep_total,
    output logic [CNT_W-1:0]    m_rep_inorder,
    output logic [CNT_W-1:0]    m_rep_retried,
    output logic [CNT_W-1:0]    m_rep_gaps,
    output logic [MISSED_W-1:0] m_rep_missed,
    output logic [CNT_W-1:0]    m_rep_dups
);

    localparam int TID_W = (NUM_TIDS > 1) ? $clog2(NUM_TIDS) : 1;

    // Folding of the incoming TID into the table range, built at elaboration.
    logic [TID_W-1:0] fold_lut [TID_SPACE];

    for (genvar i = 0; i < TID_SPACE; i++) begin : g_fold
        assign fold_lut[i] = TID_W'(i % NUM_TIDS);
    end

    logic                in_valid_reg, in_valid_next;
    logic                in_crc_reg;
    logic                in_icv_reg;
    logic                in_qos_reg;
    logic [TID_IN_W-1:0] in_tid_reg;
    logic [SEQ_W-1:0]    in_seq_reg;
    logic                in_retry_reg;

    logic [WIN_W-1:0]    window_reg;
    logic [NUM_TIDS-1:0] seen_reg, seen_next;
    logic [SEQ_W-1:0]    last_seq_reg [NUM_TIDS];

    logic [CNT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    inorder_reg, inorder_next;
    logic [CNT_W-1:0]    retried_reg, retried_next;
    logic [CNT_W-1:0]    gaps_reg, gaps_next;
    logic [MISSED_W-1:0] missed_reg, missed_next;
    logic [CNT_W-1:0]    dups_reg, dups_next;

    logic                out_valid_reg, out_valid_next;

    logic                advance;
    logic                counted;
    logic                fire;
    logic                close_window;
    logic [TID_W-1:0]    tid_idx;
    logic                was_seen;
    logic [SEQ_W-1:0]    fwd;
    logic                is_inorder;
    logic                is_gap;
    logic                is_dup;
    logic                write_seq;
    logic [CNT_W-1:0]    total_inc;
    logic [CNT_W-1:0]    inorder_upd;
    logic [CNT_W-1:0]    retried_upd;
    logic [CNT_W-1:0]    gaps_upd;
    logic [MISSED_W-1:0] missed_upd;
    logic [CNT_W-1:0]    dups_upd;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    assign counted = in_valid_reg && !in_crc_reg && !in_icv_reg && in_qos_reg;
    assign fire    = counted && advance;

    assign tid_idx    = fold_lut[in_tid_reg];
    assign was_seen   = seen_reg[tid_idx];
    assign fwd        = in_seq_reg - last_seq_reg[tid_idx];
    assign is_inorder = was_seen && (fwd == SEQ_ONE);
    assign is_gap     = was_seen && (fwd >= SEQ_TWO) && (fwd < HALF_SPACE);
    assign is_dup     = was_seen && !is_inorder && !is_gap;
    assign write_seq  = fire && (!was_seen || is_inorder || is_gap);

    assign total_inc   = total_reg + CNT_W'(1);
    assign inorder_upd = inorder_reg + CNT_W'(is_inorder);
    assign retried_upd = retried_reg + CNT_W'(in_retry_reg);
    assign gaps_upd    = gaps_reg + CNT_W'(is_gap);
    assign dups_upd    = dups_reg + CNT_W'(is_dup);
    assign missed_upd  = is_gap ? missed_reg + MISSED_W'(fwd - SEQ_ONE) : missed_reg;

    assign close_window = total_inc >= window_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end

        total_next   = total_reg;
        inorder_next = inorder_reg;
        retried_next = retried_reg;
        gaps_next    = gaps_reg;
        missed_next  = missed_reg;
        dups_next    = dups_reg;
        seen_next    = seen_reg;
        if (fire) begin
            if (close_window) begin
                total_next   = '0;
                inorder_next = '0;
                retried_next = '0;
                gaps_next    = '0;
                missed_next  = '0;
                dups_next    = '0;
                seen_next    = '0;
            end else begin
                total_next   = total_inc;
                inorder_next = inorder_upd;
                retried_next = retried_upd;
                gaps_next    = gaps_upd;
                missed_next  = missed_upd;
                dups_next    = dups_upd;
                seen_next[tid_idx] = 1'b1;
            end
        end

        out_valid_next = out_valid_reg;
        if (fire && close_window) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            window_reg    <= WINDOW_RESET;
            seen_reg      <= '0;
            total_reg     <= '0;
            inorder_reg   <= '0;
            retried_reg   <= '0;
            gaps_reg      <= '0;
            missed_reg    <= '0;
            dups_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                window_reg <= cfg_wdata;
            end
            seen_reg      <= seen_next;
            total_reg     <= total_next;
            inorder_reg   <= inorder_next;
            retried_reg   <= retried_next;
            gaps_reg      <= gaps_next;
            missed_reg    <= missed_next;
            dups_reg      <= dups_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_crc_reg   <= s_crc_error;
            in_icv_reg   <= s_icv_error;
            in_qos_reg   <= s_is_qos;
            in_tid_reg   <= s_traffic_id;
            in_seq_reg   <= s_frame_seq;
            in_retry_reg <= s_retry_flag;
        end
        if (write_seq) begin
            last_seq_reg[tid_idx] <= in_seq_reg;
        end
        if (fire && close_window) begin
            m_rep_total   <= total_inc;
            m_rep_inorder <= inorder_upd;
            m_rep_retried <= retried_upd;
            m_rep_gaps    <= gaps_upd;
            m_rep_missed  <= missed_upd;
            m_rep_dups    <= dups_upd;
        end
    end

    assign m_valid = out_valid_reg;

    // A closed window leaves all counters and seen flags cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && close_window) |=> (total_reg == '0 && seen_reg == '0 && missed_reg == '0))
        else $error("window state not cleared after report");

    // Every report covers at least one counted frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rep_total != '0))
        else $error("report with empty total");

    // The first frame of each TID in a window is not classified, so the classes stay below total.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((18'(m_rep_inorder) + 18'(m_rep_gaps) + 18'(m_rep_dups))
                     < 18'(m_rep_total)))
        else $error("classified frames exceed total");

    // An empty input register always takes a new request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stalled while empty");

    // A counted frame that does not close a window marks its TID as seen.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !close_window) |=> seen_reg[$past(tid_idx)])
        else $error("seen flag not set");

endmodule
